FILE: src/cpu16_decoded_instruction_execute_core_macros.svh
// Assertion macros for the cpu16 execute core.
// Used by the execute core only.
`ifndef CPU16_DECODED_INSTRUCTION_EXECUTE_CORE_MACROS_SVH
`define CPU16_DECODED_INSTRUCTION_EXECUTE_CORE_MACROS_SVH
// check that a condition implies another in the same cycle
`define CPU16_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");
// check that a condition implies another in the next cycle
`define CPU16_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");
`endif

FILE: src/cpu16_pkg.sv
// Package for the cpu16 execute core: opcodes, commands, payload types.
// No dependencies.
package cpu16_pkg;
  localparam int MEM_BYTES = 65536;
  localparam int MEM_AW = $clog2(MEM_BYTES);

  typedef enum logic [1:0] {
    CMD_EXEC = 2'd0, CMD_MEMWR = 2'd1, CMD_SETPC = 2'd2, CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [5:0] {
    O_ADD, O_SUB, O_SLT, O_SLTU, O_SLL, O_SRL, O_SRA, O_OR, O_AND, O_XOR,
    O_MV, O_JR, O_JALR, O_ADDI, O_SLTI, O_SLTUI, O_SLLI, O_SRLI, O_SRAI,
    O_ORI, O_ANDI, O_XORI, O_LI, O_BEQ, O_BNE, O_BZ, O_BNZ, O_BLT, O_BGE,
    O_BLTU, O_BGEU, O_SB, O_SW, O_LB, O_LBU, O_LW, O_LUI, O_AUIPC, O_J,
    O_JAL, O_ECALL
  } op_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  op;
    logic [2:0]  rd;
    logic [2:0]  rs;
    logic signed [15:0] imm_signed;
    logic [15:0] imm_unsigned;
    logic [15:0] load_addr;
    logic [15:0] load_value;
  } in_word_t;

  typedef struct packed {
    logic [15:0] pc;
    logic        reg_write;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        mem_write;
    logic        ignored;
  } out_word_t;
endpackage

FILE: src/cpu16_stream_if.sv
// Valid/ready channels, each carrying one payload word.
// Payload types come from cpu16_pkg.
interface cpu16_in_if;
  import cpu16_pkg::*;
  logic valid;
  logic ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cpu16_out_if;
  import cpu16_pkg::*;
  logic valid;
  logic ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/cpu16_decoded_instruction_execute_core.sv
// Execute core for a 16-bit, 8-register machine.
// Uses cpu16_pkg, cpu16_stream_if and the assertion macro header.
//
// Usage:
//   in  : decoded instruction words (cmd, op, rd, rs, immediates, load fields).
//   out : one result word per input word (pc, register write, store flag,
//         ignored flag).
// Timing: a word is taken in stage A, where the register file and the byte
// memory (two read addresses, one per byte lane of a word) are read into
// registers; stage B computes and writes back at the next edge. A new word is
// taken only after the previous one has written back, as the synchronous
// memory read and the write-back of registers, PC and memory require, so no
// forwarding is needed.
// Result: the word is registered into the result buffer at the edge after the
// accepting edge and is offered at the output once it is at the head.
// Output: a 2-entry result buffer. The input is held off while stage B is busy,
// while memory clears and when both entries are full, so a stalled receiver
// lets one more word through before the input stops, and nothing is dropped.
// Reset: registers, PC and the loaded flag clear, then a clearing pass zeroes
// the byte memory two bytes per cycle with the input held off.
`include "cpu16_decoded_instruction_execute_core_macros.svh"
module cpu16_decoded_instruction_execute_core
  import cpu16_pkg::*;
(
  input logic clk,
  input logic rst,
  cpu16_in_if.sink in_ch,
  cpu16_out_if.source out_ch
);
  logic [15:0] regs [8];
  logic [7:0] mem_lo [MEM_BYTES];
  logic [15:0] prog_counter;
  logic memory_loaded;
  logic clearing;
  logic [MEM_AW-2:0] clr_addr;

  logic busy;         // stage B holds a word
  in_word_t held;
  logic [15:0] a_q, b_q;
  logic [7:0] m0_q, m1_q;

  out_word_t res, res1, res_next;
  logic res_valid, res1_valid;

  assign in_ch.ready = !busy && !clearing && !res1_valid;
  wire take = in_ch.valid && in_ch.ready;
  wire fin = busy;
  wire pop = res_valid && out_ch.ready;

  // address of load in stage A
  logic [15:0] ea0, ea1;
  always_comb begin
    if (in_ch.data.op == O_LBU)
      ea0 = regs[in_ch.data.rs] + in_ch.data.imm_unsigned;
    else
      ea0 = regs[in_ch.data.rs] + 16'(in_ch.data.imm_signed);
    ea1 = ea0 + 16'd1;
  end
  wire [MEM_AW-1:0] ra0 = ea0[MEM_AW-1:0];
  wire [MEM_AW-1:0] ra1 = ea1[MEM_AW-1:0];

  always_ff @(posedge clk) begin
    if (take) begin
      held <= in_ch.data;
      a_q <= regs[in_ch.data.rd];
      b_q <= regs[in_ch.data.rs];
      m0_q <= mem_lo[ra0];
      m1_q <= mem_lo[ra1];
    end
  end

  // stage B compute
  logic [15:0] a, b, si, pc, npc, val, ea;
  logic wr, mw, take_br, wr2;
  logic [7:0] l0, l1;
  logic [15:0] br_t;
  always_comb begin
    a = a_q; b = b_q; si = held.imm_signed; pc = prog_counter;
    npc = pc + 16'd1; val = '0; wr = 1'b0; mw = 1'b0; take_br = 1'b0; wr2 = 1'b0;
    ea = b + si;
    l0 = m0_q;
    l1 = m1_q;
    br_t = pc + 16'(held.imm_signed / 16'sd2);
    case (held.op)
      O_ADD: begin val = a + b; wr = 1'b1; end
      O_SUB: begin val = a - b; wr = 1'b1; end
      O_SLT: begin val = {15'd0, $signed(a) < $signed(b)}; wr = 1'b1; end
      O_SLTU: begin val = {15'd0, a < b}; wr = 1'b1; end
      O_SLL: begin val = a << b[3:0]; wr = 1'b1; end
      O_SRL: begin val = a >> b[3:0]; wr = 1'b1; end
      O_SRA: begin val = 16'($signed(a) >>> b[3:0]); wr = 1'b1; end
      O_OR: begin val = a | b; wr = 1'b1; end
      O_AND: begin val = a & b; wr = 1'b1; end
      O_XOR: begin val = a ^ b; wr = 1'b1; end
      O_MV: begin val = b; wr = 1'b1; end
      O_JR: npc = a;
      O_JALR: begin val = npc; wr = 1'b1; npc = b; end
      O_ADDI: begin val = a + si; wr = 1'b1; end
      O_SLTI: begin val = {15'd0, $signed(a) < $signed(si)}; wr = 1'b1; end
      O_SLTUI: begin val = {15'd0, a < held.imm_unsigned}; wr = 1'b1; end
      O_SLLI: begin val = a << held.imm_unsigned[3:0]; wr = 1'b1; end
      O_SRLI: begin val = a >> held.imm_unsigned[3:0]; wr = 1'b1; end
      O_SRAI: begin val = 16'($signed(a) >>> held.imm_unsigned[3:0]); wr = 1'b1; end
      O_ORI: begin val = a | si; wr = 1'b1; end
      O_ANDI: begin val = a & si; wr = 1'b1; end
      O_XORI: begin val = a ^ si; wr = 1'b1; end
      O_LI: begin val = si; wr = 1'b1; end
      O_BEQ: take_br = a == b;
      O_BNE: take_br = a != b;
      O_BZ: take_br = a == 16'd0;
      O_BNZ: take_br = a != 16'd0;
      O_BLT: take_br = $signed(a) < $signed(b);
      O_BGE: take_br = $signed(a) >= $signed(b);
      O_BLTU: take_br = a < b;
      O_BGEU: take_br = a >= b;
      O_SB: mw = 1'b1;
      O_SW: begin mw = 1'b1; wr2 = 1'b1; end
      O_LB: begin val = {{8{l0[7]}}, l0}; wr = 1'b1; end
      O_LBU: begin val = {8'd0, l0}; wr = 1'b1; end
      O_LW: begin val = {l1, l0}; wr = 1'b1; end
      O_LUI: begin val = si << 7; wr = 1'b1; end
      O_AUIPC: begin val = pc + (si << 7); wr = 1'b1; end
      O_J: npc = br_t;
      O_JAL: begin val = npc; wr = 1'b1; npc = br_t; end
      default: ;
    endcase
    if (take_br) npc = br_t;
  end

  // result word of the step in stage B
  always_comb begin
    res_next = '0;
    res_next.pc = prog_counter;
    case (held.cmd)
      CMD_SETPC: res_next.pc = held.load_value;
      CMD_EXEC: begin
        if (!memory_loaded) res_next.ignored = 1'b1;
        else begin
          res_next.pc = npc;
          res_next.mem_write = mw;
          if (wr) begin
            res_next.reg_write = 1'b1;
            res_next.reg_index = held.rd;
            res_next.reg_value = val;
          end
        end
      end
      default: ;
    endcase
  end

  wire is_exec = fin && held.cmd == CMD_EXEC && memory_loaded;
  wire [15:0] ea_p1 = ea + 16'd1;
  wire [MEM_AW-1:0] wa0 = (held.cmd == CMD_MEMWR) ? held.load_addr[MEM_AW-1:0]
                                                   : ea[MEM_AW-1:0];
  wire [MEM_AW-1:0] wa1 = ea_p1[MEM_AW-1:0];
  wire mw0 = (fin && held.cmd == CMD_MEMWR) || (is_exec && mw);
  wire mw1 = is_exec && wr2;
  wire [7:0] wd0 = (held.cmd == CMD_MEMWR) ? held.load_value[7:0] : a[7:0];

  // two write ports: low byte lane and high byte lane of a word store
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem_lo[{clr_addr, 1'b0}] <= 8'h00;
      mem_lo[{clr_addr, 1'b1}] <= 8'h00;
    end else begin
      if (mw0) mem_lo[wa0] <= wd0;
      if (mw1) mem_lo[wa1] <= a[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      prog_counter <= '0;
      memory_loaded <= 1'b0;
      clearing <= 1'b1;
      clr_addr <= '0;
      for (int i = 0; i < 8; i++) regs[i] <= '0;
    end else begin
      busy <= take;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (&clr_addr) clearing <= 1'b0;
      end
      if (fin) begin
        case (held.cmd)
          CMD_MEMWR: memory_loaded <= 1'b1;
          CMD_SETPC: prog_counter <= held.load_value;
          CMD_EXEC: begin
            if (memory_loaded) begin
              prog_counter <= npc;
              if (wr) regs[held.rd] <= val;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result buffer: res is the head, res1 the second entry
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      res1_valid <= 1'b0;
    end else if (!res_valid || (pop && !res1_valid)) begin
      res_valid <= fin;
      if (fin) res <= res_next;
    end else if (pop) begin
      res <= res1;
      res1_valid <= fin;
      if (fin) res1 <= res_next;
    end else if (fin) begin
      res1 <= res_next;
      res1_valid <= 1'b1;
    end
  end

  assign out_ch.valid = res_valid;
  assign out_ch.data = res;

  `CPU16_ASSERT_NEXT(a_busy_once, clk, rst, busy, !busy)
  `CPU16_ASSERT_NEXT(a_result, clk, rst, busy, out_ch.valid)
  `CPU16_ASSERT_IMP(a_no_take_busy, clk, rst, busy, !in_ch.ready)
  `CPU16_ASSERT_IMP(a_no_take_clear, clk, rst, clearing, !in_ch.ready)
endmodule

FILE: tb/cpu16_tb_pkg.sv
`timescale 1ns / 100ps
// Testbench package: queue types shared by the driver, monitor and stimulus.
// Depends on cpu16_pkg.
package cpu16_tb_pkg;
  import cpu16_pkg::*;
  typedef in_word_t  instr_q_t[$];
  typedef out_word_t result_q_t[$];
endpackage

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for cpu16_decoded_instruction_execute_core: drives decoded
// instruction words, predicts each result word, and checks them in order.
// Depends on cpu16_pkg, cpu16_tb_pkg and the cpu16 stream interfaces.
module tb_top;
  import cpu16_pkg::*;
  import cpu16_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  cpu16_in_if  in_ch();
  cpu16_out_if out_ch();

  cpu16_decoded_instruction_execute_core u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  // predictor state
  logic [15:0] gpr [8];
  logic [15:0] cur_pc;
  logic [7:0]  bytes [int];
  bit          loaded;

  instr_q_t  pending;
  result_q_t exp_results;
  int errors, n_checked, n_sent;
  int cycles;
  bit stim_done;
  int hold_off;
  bit hold_req;
  bit in_acc;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    errors++;
    $display("mismatch on %s at result %0d: got %h want %h", what, n_checked, got, want);
  endtask

  function automatic logic [7:0] rd_byte(input logic [15:0] a);
    return bytes.exists(a) ? bytes[a] : 8'h00;
  endfunction

  function automatic logic [15:0] branch_target(input logic [15:0] p, input logic [15:0] imm);
    int off;
    off = $signed(imm) / 2;
    return p + 16'(off);
  endfunction

  function automatic out_word_t execute(input in_word_t w);
    out_word_t r;
    logic [15:0] a, b, npc, val, si, ea;
    logic [7:0] lb;
    bit wr, mw, take;
    r = '0; wr = 0; mw = 0; take = 0; val = '0;
    if (w.cmd == CMD_MEMWR) begin
      bytes[w.load_addr] = w.load_value[7:0];
      loaded = 1;
    end else if (w.cmd == CMD_SETPC) begin
      cur_pc = w.load_value;
    end else if (w.cmd == CMD_EXEC && !loaded) begin
      r.ignored = 1'b1;
    end else if (w.cmd == CMD_EXEC) begin
      a = gpr[w.rd]; b = gpr[w.rs];
      npc = cur_pc + 16'd1;
      si = w.imm_signed;
      ea = b + si;
      wr = 1;
      case (op_t'(w.op))
        O_ADD:   val = a + b;
        O_SUB:   val = a - b;
        O_SLT:   val = 16'($signed(a) < $signed(b));
        O_SLTU:  val = 16'(a < b);
        O_SLL:   val = a << b[3:0];
        O_SRL:   val = a >> b[3:0];
        O_SRA:   val = $signed(a) >>> b[3:0];
        O_OR:    val = a | b;
        O_AND:   val = a & b;
        O_XOR:   val = a ^ b;
        O_MV:    val = b;
        O_JR:    begin wr = 0; npc = a; end
        O_JALR:  begin val = npc; npc = b; end
        O_ADDI:  val = a + si;
        O_SLTI:  val = 16'($signed(a) < $signed(si));
        O_SLTUI: val = 16'(a < w.imm_unsigned);
        O_SLLI:  val = a << w.imm_unsigned[3:0];
        O_SRLI:  val = a >> w.imm_unsigned[3:0];
        O_SRAI:  val = $signed(a) >>> w.imm_unsigned[3:0];
        O_ORI:   val = a | si;
        O_ANDI:  val = a & si;
        O_XORI:  val = a ^ si;
        O_LI:    val = si;
        O_BEQ:   begin wr = 0; take = (a == b); end
        O_BNE:   begin wr = 0; take = (a != b); end
        O_BZ:    begin wr = 0; take = (a == 0); end
        O_BNZ:   begin wr = 0; take = (a != 0); end
        O_BLT:   begin wr = 0; take = ($signed(a) < $signed(b)); end
        O_BGE:   begin wr = 0; take = ($signed(a) >= $signed(b)); end
        O_BLTU:  begin wr = 0; take = (a < b); end
        O_BGEU:  begin wr = 0; take = (a >= b); end
        O_SB:    begin wr = 0; mw = 1; bytes[ea] = a[7:0]; end
        O_SW:    begin wr = 0; mw = 1; bytes[ea] = a[7:0]; bytes[ea + 16'd1] = a[15:8]; end
        O_LB:    begin lb = rd_byte(ea); val = {{8{lb[7]}}, lb}; end
        O_LBU:   val = {8'h00, rd_byte(b + w.imm_unsigned)};
        O_LW:    val = {rd_byte(ea + 16'd1), rd_byte(ea)};
        O_LUI:   val = si << 7;
        O_AUIPC: val = cur_pc + (si << 7);
        O_J:     begin wr = 0; npc = branch_target(cur_pc, w.imm_signed); end
        O_JAL:   begin val = npc; npc = branch_target(cur_pc, w.imm_signed); end
        default: wr = 0;
      endcase
      if (take) npc = branch_target(cur_pc, w.imm_signed);
      if (wr) gpr[w.rd] = val;
      cur_pc = npc;
    end
    r.pc = cur_pc;
    r.reg_write = wr;
    r.reg_index = wr ? w.rd : 3'd0;
    r.reg_value = wr ? val : 16'd0;
    r.mem_write = mw;
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
           ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // driver
  int in_gap;
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      in_gap <= 0;
    end else if (!in_ch.valid || in_acc) begin
      // previous word (if any) was taken at the rising edge just passed
      if (in_gap > 0 || pending.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending.pop_front();
        in_gap <= gap_len();
      end
    end
  end

  always @(posedge clk) begin
    in_acc <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      exp_results.push_back(execute(in_ch.data));
      n_sent++;
    end
  end

  // receiver ready, with one long hold-off counted here
  int out_gap;
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
      hold_off <= 0;
    end else if (hold_req && hold_off == 0) begin
      hold_off <= 300;
      out_ch.ready <= 1'b0;
    end else if (hold_off > 1) begin
      hold_off <= hold_off - 1;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ch.ready <= 1'b0;
      if (hold_off == 1) hold_off <= 0;
    end else begin
      out_ch.ready <= 1'b1;
      out_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (hold_off == 1) hold_off <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t want, got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (exp_results.size() == 0) begin
        report("unexpected word pc", got.pc, 16'h0000);
      end else begin
        want = exp_results.pop_front();
        if (got.pc !== want.pc) report("pc", got.pc, want.pc);
        if (got.reg_write !== want.reg_write) report("reg_write", got.reg_write, want.reg_write);
        if (got.reg_index !== want.reg_index) report("reg_index", got.reg_index, want.reg_index);
        if (got.reg_value !== want.reg_value) report("reg_value", got.reg_value, want.reg_value);
        if (got.mem_write !== want.mem_write) report("mem_write", got.mem_write, want.mem_write);
        if (got.ignored !== want.ignored) report("ignored", got.ignored, want.ignored);
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic in_word_t mk(input cmd_t c, input op_t o, input int d, input int s,
                                  input logic [15:0] imm, input logic [15:0] la,
                                  input logic [15:0] lv);
    in_word_t w;
    w.cmd = c; w.op = o; w.rd = 3'(d); w.rs = 3'(s);
    w.imm_signed = imm; w.imm_unsigned = imm;
    w.load_addr = la; w.load_value = lv;
    return w;
  endfunction

  function automatic in_word_t rand_exec();
    in_word_t w;
    w.cmd = CMD_EXEC;
    w.op = ($urandom_range(0, 40) == 0) ? 6'($urandom_range(41, 63)) : 6'($urandom_range(0, 40));
    w.rd = 3'($urandom); w.rs = 3'($urandom);
    case ($urandom_range(0, 3))
      0: w.imm_signed = 16'($urandom_range(0, 31)) - 16'd16;
      1: w.imm_signed = 16'($urandom_range(0, 255));
      default: w.imm_signed = 16'($urandom);
    endcase
    w.imm_unsigned = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 255)) : 16'($urandom);
    w.load_addr = 16'($urandom);
    w.load_value = 16'($urandom);
    return w;
  endfunction

  initial begin
    in_word_t w;
    int r;
    errors = 0; n_checked = 0; n_sent = 0; cycles = 0;
    stim_done = 0; hold_req = 0;
    cur_pc = '0; loaded = 0;
    for (int i = 0; i < 8; i++) gpr[i] = '0;
    in_ch.valid = 1'b0; in_ch.data = '0; out_ch.ready = 1'b0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: execute before any memory write is ignored, odd commands
    pending.push_back(mk(CMD_EXEC, O_ADDI, 1, 0, 16'd5, 0, 0));
    pending.push_back(mk(CMD_NONE, O_ADD, 0, 0, 0, 16'hFFFF, 16'hFFFF));
    pending.push_back(mk(CMD_MEMWR, O_ADD, 0, 0, 0, 16'hFFFF, 16'h12AB));
    pending.push_back(mk(CMD_MEMWR, O_ADD, 0, 0, 0, 16'h0000, 16'h0080));
    pending.push_back(mk(CMD_EXEC, O_LI, 1, 0, 16'h8000, 0, 0));
    pending.push_back(mk(CMD_EXEC, O_LI, 2, 0, 16'hFFFF, 0, 0));
    pending.push_back(mk(CMD_EXEC, O_LI, 3, 0, 16'h7FFF, 0, 0));
    pending.push_back(mk(CMD_EXEC, O_SRA, 4, 2, 0, 0, 0));
    pending.push_back(mk(CMD_EXEC, O_SLT, 1, 3, 0, 0, 0));
    pending.push_back(mk(CMD_EXEC, O_SLTI, 2, 0, 16'h0001, 0, 0));
    pending.push_back(mk(CMD_EXEC, O_SRAI, 3, 0, 16'hFFF3, 0, 0));
    pending.push_back(mk(CMD_EXEC, O_LW, 5, 0, 16'hFFFF, 0, 0));
    pending.push_back(mk(CMD_EXEC, O_LB, 6, 0, 16'h0000, 0, 0));
    pending.push_back(mk(CMD_EXEC, O_SW, 3, 0, 16'hFFFF, 0, 0));
    pending.push_back(mk(CMD_EXEC, O_JALR, 7, 7, 0, 0, 0));
    pending.push_back(mk(CMD_EXEC, O_J, 0, 0, 16'hFFFF, 0, 0));
    pending.push_back(mk(CMD_EXEC, O_JAL, 1, 0, 16'h8001, 0, 0));
    pending.push_back(mk(CMD_SETPC, O_ADD, 0, 0, 0, 0, 16'hFFFF));
    pending.push_back(mk(CMD_EXEC, O_AUIPC, 2, 0, 16'h01FF, 0, 0));
    pending.push_back(mk(CMD_EXEC, O_ECALL, 0, 0, 0, 0, 0));
    pending.push_back(mk(CMD_EXEC, op_t'(6'd63), 0, 0, 0, 0, 0));
    pending.push_back(mk(CMD_EXEC, O_LUI, 4, 0, 16'h01FF, 0, 0));
    pending.push_back(mk(CMD_EXEC, O_LBU, 5, 0, 16'hFFFF, 0, 0));

    // random: mostly execute with a sprinkling of memory writes, PC sets and CMD_NONE words
    for (int i = 0; i < 1330; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) w = mk(CMD_MEMWR, op_t'(6'($urandom)), 0, 0, 16'($urandom),
                         16'($urandom), 16'($urandom));
      else if (r == 1) w = mk(CMD_SETPC, O_ADD, 0, 0, 0, 0, 16'($urandom));
      else if (r == 2) w = mk(CMD_NONE, O_ADD, 0, 0, 0, 0, 0);
      else w = rand_exec();
      pending.push_back(w);
      if (i == 400) begin
        // long receiver stall while input keeps offering words
        wait (pending.size() < 300);
        hold_req = 1;
        @(posedge clk);
        hold_req = 0;
      end
    end
    wait (pending.size() == 0 && !in_ch.valid);
    wait (exp_results.size() == 0);
    repeat (20) @(posedge clk);
    $display("sent %0d words, checked %0d results, incl. a long output stall", n_sent, n_checked);
    if (errors == 0 && exp_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
